### src/gtp_pkg.sv
package gtp_pkg;

  localparam int CORDIC_STEPS = 16;

  localparam logic [2:0] REG_TARGET_X    = 3'd0;
  localparam logic [2:0] REG_TARGET_Y    = 3'd1;
  localparam logic [2:0] REG_TARGET_HEAD = 3'd2;
  localparam logic [2:0] REG_POS_TOL     = 3'd3;
  localparam logic [2:0] REG_HEAD_TOL    = 3'd4;

  localparam logic [1:0] PHASE_TURNING = 2'd0;
  localparam logic [1:0] PHASE_ALIGNED = 2'd1;
  localparam logic [1:0] PHASE_FINAL   = 2'd2;

  localparam logic [1:0] OUT_RUNNING   = 2'd0;
  localparam logic [1:0] OUT_REACHED   = 2'd1;
  localparam logic [1:0] OUT_CANCELLED = 2'd2;
  localparam logic [1:0] OUT_IDLE      = 2'd3;

  localparam logic signed [16:0] PI_Q12       = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12   = 17'sd25736;
  localparam logic signed [23:0] HALF_PI_Q20  = 24'sd1647100;
  localparam logic [14:0]        ALIGN_THRESH = 15'd410;
  localparam logic [11:0]        FWD_MAX      = 12'd1229;
  localparam logic signed [15:0] TURN_MAX     = 16'sd3277;
  localparam logic signed [18:0] FINAL_MAX    = 19'sd2048;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [14:0] target_heading;
    logic [15:0]        position_tolerance;
    logic [12:0]        heading_tolerance;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic [31:0] distance;
  } dist_stat_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } cordic_stat_t;

  // Arctangent of 2^-i in Q.20 radians.
  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] r;
    case (i)
      5'd0:  r = 20'd823550;
      5'd1:  r = 20'd486170;
      5'd2:  r = 20'd256879;
      5'd3:  r = 20'd130396;
      5'd4:  r = 20'd65451;
      5'd5:  r = 20'd32757;
      5'd6:  r = 20'd16383;
      5'd7:  r = 20'd8192;
      5'd8:  r = 20'd4096;
      5'd9:  r = 20'd2048;
      5'd10: r = 20'd1024;
      5'd11: r = 20'd512;
      5'd12: r = 20'd256;
      5'd13: r = 20'd128;
      5'd14: r = 20'd64;
      5'd15: r = 20'd32;
      5'd16: r = 20'd16;
      5'd17: r = 20'd8;
      5'd18: r = 20'd4;
      5'd19: r = 20'd2;
      5'd20: r = 20'd1;
      5'd21: r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

### src/gtp_if.sv
interface gtp_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [14:0] pose_heading;
  logic               cancel;
  logic               start_req;

  modport source (output valid, pose_x, pose_y, pose_heading, cancel, start_req,
                  input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, cancel, start_req,
                output ready);
endinterface

interface gtp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] forward_speed;
  logic signed [12:0] turn_rate;
  logic [31:0]        distance_left;
  logic signed [14:0] bearing_error;
  logic [1:0]         phase;
  logic [1:0]         outcome;

  modport source (output valid, forward_speed, turn_rate, distance_left, bearing_error,
                  phase, outcome, input ready);
  modport sink (input valid, forward_speed, turn_rate, distance_left, bearing_error,
                phase, outcome, output ready);
endinterface

### src/go_to_pose_controller_top.sv
// From an accepted pose transaction to its command transaction the block runs the serial
// squaring steps and the square-root steps, enters the result state and then loads the
// output register. A new pose transaction is accepted only once the previous command has
// been written to the output register, which waits while that register is stalled; the
// bit-serial square root of the squared distance sets the pace, while the CORDIC runs
// beside it.
// Reset: asynchronous, active low; the run is idle and the goal registers take defaults.
module go_to_pose_controller_top
  import gtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gtp_pose_if.sink    pose_i,
  gtp_cmd_if.source   cmd_o
);

  // The sequencer is one-hot: wait for a pose, run the serial units, then
  // form the command and place it in the output register.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;

  dist_stat_t   dist_st;
  cordic_stat_t cor_st;

  logic               accept, emit;
  logic signed [32:0] dx, dy;
  logic [32:0]        ux, uy;
  logic signed [14:0] ph_q;
  logic               cancel_q, start_q;
  logic               active_q, active_d;

  gtp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Goal offset is taken when the pose transaction is accepted.
  assign pose_i.ready = (state_q == S_IDLE);
  assign accept       = pose_i.valid && pose_i.ready;
  assign dx = 33'(cfg.target_x) - 33'(pose_i.pose_x);
  assign dy = 33'(cfg.target_y) - 33'(pose_i.pose_y);
  assign ux = dx[32] ? -dx : dx;
  assign uy = dy[32] ? -dy : dy;

  gtp_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ux_i    (ux[31:0]),
    .uy_i    (uy[31:0]),
    .stat_o  (dist_st)
  );

  gtp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .dx_i    (dx),
    .dy_i    (dy),
    .stat_o  (cor_st)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ph_q     <= pose_i.pose_heading;
      cancel_q <= pose_i.cancel;
      start_q  <= pose_i.start_req;
    end
  end

  // Result stage. The bearing and the final heading error each need at most
  // one wrap step, since both operands lie within the 15-bit range.
  logic signed [16:0] a0, a1, f0, ferr;
  logic signed [14:0] bearing, mag;
  logic signed [16:0] fmag;
  logic               near, act_now;
  logic signed [27:0] tprod;
  logic signed [15:0] tdrv;
  logic signed [19:0] t3;
  logic signed [18:0] tfin;
  logic signed [11:0] fwd_c;
  logic signed [12:0] turn_c;
  logic [1:0]         phase_c, outcome_c;

  always_comb begin
    a0 = 17'(cor_st.angle) - 17'(ph_q);
    if (a0 > PI_Q12) a1 = a0 - TWO_PI_Q12;
    else if (a0 < -PI_Q12) a1 = a0 + TWO_PI_Q12;
    else a1 = a0;
    bearing = a1[14:0];
    mag     = bearing[14] ? -bearing : bearing;

    f0 = 17'(cfg.target_heading) - 17'(ph_q);
    if (f0 > PI_Q12) ferr = f0 - TWO_PI_Q12;
    else if (f0 < -PI_Q12) ferr = f0 + TWO_PI_Q12;
    else ferr = f0;
    fmag = ferr[16] ? -ferr : ferr;

    near = dist_st.distance < {16'd0, cfg.position_tolerance};
    if (near) phase_c = PHASE_FINAL;
    else if ($unsigned(mag) > ALIGN_THRESH) phase_c = PHASE_TURNING;
    else phase_c = PHASE_ALIGNED;

    tprod = (28'(bearing) * 28'sd4915 + 28'sd2048) >>> 12;
    tdrv  = tprod[15:0];
    t3    = (20'(ferr) * 20'sd3 + 20'sd1) >>> 1;
    tfin  = t3[18:0];

    act_now   = active_q || start_q;
    active_d  = act_now;
    fwd_c     = '0;
    turn_c    = '0;
    outcome_c = OUT_RUNNING;
    if (!act_now) begin
      outcome_c = OUT_IDLE;
    end else if (cancel_q) begin
      active_d  = 1'b0;
      outcome_c = OUT_CANCELLED;
    end else if (near) begin
      if (fmag > 17'($unsigned(cfg.heading_tolerance))) begin
        if (tfin > FINAL_MAX) turn_c = 13'(FINAL_MAX);
        else if (tfin < -FINAL_MAX) turn_c = -13'(FINAL_MAX);
        else turn_c = tfin[12:0];
      end else begin
        active_d  = 1'b0;
        outcome_c = OUT_REACHED;
      end
    end else begin
      fwd_c = (dist_st.distance[31:5] > 27'(FWD_MAX)) ? FWD_MAX : dist_st.distance[16:5];
      if (tdrv > TURN_MAX) turn_c = 13'(TURN_MAX);
      else if (tdrv < -TURN_MAX) turn_c = -13'(TURN_MAX);
      else turn_c = tdrv[12:0];
    end
  end

  // A finished command waits in the output register; the next result is
  // written only once that slot has been taken.
  assign emit = (state_q == S_FIN) && (!cmd_o.valid || cmd_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RUN;
      S_RUN:  if (dist_st.done && cor_st.done) state_d = S_FIN;
      S_FIN:  if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      cmd_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        active_q    <= active_d;
        cmd_o.valid <= 1'b1;
      end else if (cmd_o.ready) begin
        cmd_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cmd_o.forward_speed <= fwd_c;
      cmd_o.turn_rate     <= turn_c;
      cmd_o.distance_left <= dist_st.distance;
      cmd_o.bearing_error <= bearing;
      cmd_o.phase         <= phase_c;
      cmd_o.outcome       <= outcome_c;
    end
  end

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> !pose_i.ready)
    else $error("pose input ready during a run");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN))
    else $error("accepted pose did not start the serial units");

  a_stopped_zero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && (cmd_o.outcome != OUT_RUNNING)) |->
      (cmd_o.forward_speed == 12'sd0 && cmd_o.turn_rate == 13'sd0))
    else $error("nonzero command outside a running state");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid |-> (cmd_o.phase != 2'd3))
    else $error("illegal phase code");

endmodule

### src/gtp_regs.sv
module gtp_regs
  import gtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x           <= '0;
      cfg_q.target_y           <= '0;
      cfg_q.target_heading     <= '0;
      cfg_q.position_tolerance <= 16'd6554;
      cfg_q.heading_tolerance  <= 13'd205;
    end else if (wr) begin
      case (idx)
        REG_TARGET_X:    cfg_q.target_x           <= pwdata;
        REG_TARGET_Y:    cfg_q.target_y           <= pwdata;
        REG_TARGET_HEAD: cfg_q.target_heading     <= pwdata[14:0];
        REG_POS_TOL:     cfg_q.position_tolerance <= pwdata[15:0];
        REG_HEAD_TOL:    cfg_q.heading_tolerance  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_X:    prdata = cfg_q.target_x;
      REG_TARGET_Y:    prdata = cfg_q.target_y;
      REG_TARGET_HEAD: prdata = {17'd0, cfg_q.target_heading};
      REG_POS_TOL:     prdata = {16'd0, cfg_q.position_tolerance};
      REG_HEAD_TOL:    prdata = {19'd0, cfg_q.heading_tolerance};
      default:         prdata = '0;
    endcase
  end

endmodule

### src/gtp_dist.sv
module gtp_dist
  import gtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] ux_i,
  input  logic [31:0] uy_i,
  output dist_stat_t  stat_o
);

  // Serial squaring (one multiplier bit per cycle) followed by a restoring
  // square root that retires one result bit per cycle.
  logic        busy_q, busy_d, sqrt_q, sqrt_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] ux_q, ux_d, uy_q, uy_d;
  logic [63:0] mx_q, mx_d, my_q, my_d;
  logic [65:0] acc_q, acc_d;
  logic [35:0] rem_q, rem_d, rem_sh, trial;
  logic [32:0] root_q, root_d;

  assign rem_sh = {rem_q[33:0], acc_q[65:64]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    ux_d   = ux_q;
    uy_d   = uy_q;
    mx_d   = mx_q;
    my_d   = my_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = 1'b0;
      done_d = 1'b0;
      cnt_d  = '0;
      ux_d   = ux_i;
      uy_d   = uy_i;
      mx_d   = {32'd0, ux_i};
      my_d   = {32'd0, uy_i};
      acc_d  = '0;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q && !sqrt_q) begin
      acc_d = acc_q + (ux_q[0] ? {2'b00, mx_q} : 66'd0)
                    + (uy_q[0] ? {2'b00, my_q} : 66'd0);
      ux_d  = ux_q >> 1;
      uy_d  = uy_q >> 1;
      mx_d  = mx_q << 1;
      my_d  = my_q << 1;
      if (cnt_q == 6'd31) begin
        sqrt_d = 1'b1;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end else if (busy_q) begin
      acc_d = acc_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[31:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[31:0], 1'b0};
      end
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sqrt_q <= sqrt_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q   <= ux_d;
    uy_q   <= uy_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.distance = root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];

endmodule

### src/gtp_cordic.sv
module gtp_cordic
  import gtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  output cordic_stat_t       stat_o
);

  logic                busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  logic [4:0]          it_q, it_d;
  logic signed [59:0]  x_q, x_d, y_q, y_d, xs, ys, x0, y0;
  logic signed [23:0]  z_q, z_d, zr, atan_s;

  assign x0     = 60'(dx_i) <<< 24;
  assign y0     = 60'(dy_i) <<< 24;
  assign xs     = x_q >>> it_q;
  assign ys     = y_q >>> it_q;
  assign atan_s = $signed({4'd0, atan_q20(it_q)});

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    zero_d = zero_q;
    it_d   = it_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      it_d   = '0;
      zero_d = (dx_i == 33'sd0) && (dy_i == 33'sd0);
      x_d    = x0;
      y_d    = y0;
      z_d    = '0;
      // Left half plane is rotated into the right one first.
      if (dx_i < 33'sd0) begin
        if (dy_i >= 33'sd0) begin
          x_d = y0;
          y_d = -x0;
          z_d = HALF_PI_Q20;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -HALF_PI_Q20;
        end
      end
    end else if (busy_q) begin
      if (y_q > 60'sd0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end
      if (it_q == 5'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        it_d = it_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign zr           = z_q + 24'sd128;
  assign stat_o.done  = done_q;
  assign stat_o.angle = zero_q ? 16'sd0 : zr[23:8];

endmodule

### verif/go_to_pose_controller_checker.sv
`timescale 1ns / 1ps

module go_to_pose_controller_checker
  import gtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  gtp_pose_if.sink    pose_mon,
  gtp_cmd_if.sink     cmd_mon,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic signed [11:0] fwd;
    logic signed [12:0] turn;
    logic [31:0]        distance;
    logic signed [14:0] bearing;
    logic [1:0]         phase;
    logic [1:0]         outcome;
  } cmd_t;

  cmd_t        cmd_queue[$];
  cfg_t        goal;
  logic        run_active;
  int          mismatches;

  assign fail_count    = mismatches;
  assign pending_count = cmd_queue.size();

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_angle(longint a);
    while (a > 12868) a -= 25736;
    while (a < -12868) a += 25736;
    return a;
  endfunction

  function automatic longint limit(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint bearing_angle(longint dy, longint dx);
    longint    x, y, z, t, xs, ys;
    longint    tab[24];
    tab = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0};
    if (dx == 0 && dy == 0) return 0;
    x = dx * 16777216;
    y = dy * 16777216;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1647100;
      end else begin
        t = x; x = -y; y = t; z = -1647100;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic cmd_t steer(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [14:0] ph, input logic cancel,
                                 input logic start);
    cmd_t            c;
    longint          dx, dy, ux, uy, brg, mag, ferr, fmag, fwd, turn, dist_v;
    longint unsigned sq, sum;
    logic            near;
    dx = longint'(goal.target_x) - longint'(px);
    dy = longint'(goal.target_y) - longint'(py);
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    sq = longint'(ux) * longint'(ux);
    sum = sq + longint'(uy) * longint'(uy);
    dist_v = (sum < sq) ? 64'hFFFF_FFFF : int_sqrt(sum);
    if (dist_v > 64'hFFFF_FFFF) dist_v = 64'hFFFF_FFFF;
    brg = wrap_angle(bearing_angle(dy, dx) - longint'(ph));
    mag = brg < 0 ? -brg : brg;
    near = dist_v < longint'(goal.position_tolerance);
    fwd = 0;
    turn = 0;
    c.phase = near ? PHASE_FINAL : (mag > 410 ? PHASE_TURNING : PHASE_ALIGNED);
    if (start) run_active = 1'b1;
    if (!run_active) begin
      c.outcome = OUT_IDLE;
    end else if (cancel) begin
      run_active = 1'b0;
      c.outcome = OUT_CANCELLED;
    end else if (near) begin
      ferr = wrap_angle(longint'(goal.target_heading) - longint'(ph));
      fmag = ferr < 0 ? -ferr : ferr;
      if (fmag > longint'(goal.heading_tolerance)) begin
        turn = limit(shr_floor(3 * ferr + 1, 1), 2048);
        c.outcome = OUT_RUNNING;
      end else begin
        run_active = 1'b0;
        c.outcome = OUT_REACHED;
      end
    end else begin
      fwd = limit(dist_v >> 5, 1229);
      turn = limit(shr_floor(brg * 4915 + 2048, 12), 3277);
      c.outcome = OUT_RUNNING;
    end
    c.fwd = fwd[11:0];
    c.turn = turn[12:0];
    c.distance = dist_v[31:0];
    c.bearing = brg[14:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t got, want;
    if (!rst_ni) begin
      goal.target_x <= '0;
      goal.target_y <= '0;
      goal.target_heading <= '0;
      goal.position_tolerance <= 16'd6554;
      goal.heading_tolerance <= 13'd205;
      run_active = 1'b0;
      mismatches <= 0;
      cmd_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TARGET_X:    goal.target_x <= pwdata;
          REG_TARGET_Y:    goal.target_y <= pwdata;
          REG_TARGET_HEAD: goal.target_heading <= pwdata[14:0];
          REG_POS_TOL:     goal.position_tolerance <= pwdata[15:0];
          REG_HEAD_TOL:    goal.heading_tolerance <= pwdata[12:0];
          default: ;
        endcase
      end
      if (pose_mon.valid && pose_mon.ready)
        cmd_queue.push_back(steer(pose_mon.pose_x, pose_mon.pose_y, pose_mon.pose_heading,
                                  pose_mon.cancel, pose_mon.start_req));
      if (cmd_mon.valid && cmd_mon.ready) begin
        got = '{cmd_mon.forward_speed, cmd_mon.turn_rate, cmd_mon.distance_left,
                cmd_mon.bearing_error, cmd_mon.phase, cmd_mon.outcome};
        if (cmd_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected command transaction %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("command mismatch: expected %p, got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

### verif/go_to_pose_controller_top_tb.sv
`timescale 1ns / 1ps

module go_to_pose_controller_top_tb;
  import gtp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending_count;
  int          src_idle_pct, snk_idle_pct;
  longint      cycle_count;

  gtp_pose_if pose_bus ();
  gtp_cmd_if  cmd_bus ();

  go_to_pose_controller_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pose_i(pose_bus.sink), .cmd_o(cmd_bus.source)
  );

  go_to_pose_controller_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pose_mon(pose_bus.sink), .cmd_mon(cmd_bus.sink),
    .fail_count, .pending_count
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The watchdog covers the slowest correct run: each transaction costs the
  // block's serial computation plus sender gaps and receiver stalls, with a wide margin.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 1_500_000) begin
        $display("** go_to_pose_controller_top: FAILED **");
        $finish;
      end
    end
  end

  // The receiver stalls at random by the current idle percentage.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.ready <= 1'b0;
    end else begin
      cmd_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drops the offer, waits until every expected command has arrived, then lets
  // the block settle.
  task automatic drain();
    pose_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Offers one pose transaction and returns at its handshake; valid stays up
  // until the next call idles or offers the next pose.
  task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                           input logic [14:0] ph, input logic cancel, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      pose_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pose_bus.valid <= 1'b1;
    pose_bus.pose_x <= px;
    pose_bus.pose_y <= py;
    pose_bus.pose_heading <= ph;
    pose_bus.cancel <= cancel;
    pose_bus.start_req <= start;
    @(posedge clk_i);
    while (!pose_bus.ready) @(posedge clk_i);
  endtask

  function automatic logic [14:0] rand_angle();
    return 15'($signed($urandom_range(25736)) - 12868);
  endfunction

  // Poses mostly near the goal, some anywhere, so that runs reach the final alignment and finish.
  task automatic random_pose(input logic signed [31:0] gx, input logic signed [31:0] gy);
    logic [31:0] px, py;
    int          kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      px = $urandom;
      py = $urandom;
    end else if (kind < 5) begin
      px = gx + 32'($signed($urandom_range(20000)) - 10000);
      py = gy + 32'($signed($urandom_range(20000)) - 10000);
    end else begin
      px = gx + 32'($signed($urandom_range(4_000_000)) - 2_000_000);
      py = gy + 32'($signed($urandom_range(4_000_000)) - 2_000_000);
    end
    send_pose(px, py, ($urandom_range(3) == 0) ? 15'($urandom) : rand_angle(),
              $urandom_range(19) == 0, $urandom_range(9) == 0);
  endtask

  initial begin
    logic signed [31:0] gx, gy;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pose_bus.valid = 1'b0;
    pose_bus.pose_x = '0; pose_bus.pose_y = '0; pose_bus.pose_heading = '0;
    pose_bus.cancel = 1'b0; pose_bus.start_req = 1'b0;
    src_idle_pct = 30;
    snk_idle_pct = 64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default goal, idle and cancel-while-idle, then extreme poses.
    send_pose(32'd0, 32'd0, 15'd0, 1'b0, 1'b0);
    send_pose(32'd100, 32'd0, 15'd0, 1'b1, 1'b0);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'h7FFF, 1'b0, 1'b1);
    send_pose(32'h8000_0000, 32'h8000_0000, 15'h4000, 1'b0, 1'b0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 15'sd12868, 1'b0, 1'b1);
    send_pose(-32'sd65536, 32'd0, -15'sd12868, 1'b0, 1'b0);
    send_pose(-32'sd65536, -32'sd10, 15'd0, 1'b0, 1'b0);
    send_pose(32'd0, 32'd65536, 15'd0, 1'b1, 1'b0);
    // Start and reach at once: on the goal, heading aligned.
    send_pose(32'd0, 32'd0, 15'd100, 1'b0, 1'b1);
    // Final alignment with large heading error, then a start while active.
    send_pose(32'd10, 32'd0, 15'd0, 1'b0, 1'b1);
    send_pose(32'd10, 32'd5, -15'sd12000, 1'b0, 1'b1);
    send_pose(32'd10, 32'd5, 15'd1000, 1'b0, 1'b0);
    send_pose(32'd10, 32'd5, 15'd0, 1'b0, 1'b0);
    send_pose(32'd500000, 32'd500000, 15'd0, 1'b0, 1'b1);
    send_pose(32'd500000, 32'd500000, 15'd0, 1'b1, 1'b1);
    drain();

    // Extreme configuration.
    reg_write(REG_TARGET_X, 32'h7FFF_FFFF);
    reg_write(REG_TARGET_Y, 32'h8000_0000);
    reg_write(REG_TARGET_HEAD, 32'h0000_7FFF);
    reg_write(REG_POS_TOL, 32'hFFFF_FFFF);
    reg_write(REG_HEAD_TOL, 32'h0000_1FFF);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 15'h2000, 1'b0, 1'b1);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 15'd0, 1'b0, 1'b1);
    send_pose(32'h7FFF_0000, 32'h8000_1000, 15'd0, 1'b0, 1'b0);
    drain();
    reg_write(REG_POS_TOL, 32'd0);
    reg_write(REG_HEAD_TOL, 32'd0);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 15'd0, 1'b0, 1'b1);
    send_pose(32'h0, 32'h0, 15'd0, 1'b0, 1'b0);
    drain();

    // Random phases: each picks a new goal and runs one of three idle profiles.
    for (int ph = 0; ph < 6; ph++) begin
      gx = (ph == 0) ? 32'sd0 : 32'($urandom_range(2_000_000_000)) - 32'sd1_000_000_000;
      gy = (ph == 0) ? 32'sd0 : 32'($urandom_range(2_000_000_000)) - 32'sd1_000_000_000;
      if (ph == 5) begin
        gx = $urandom;
        gy = $urandom;
      end
      reg_write(REG_TARGET_X, gx);
      reg_write(REG_TARGET_Y, gy);
      reg_write(REG_TARGET_HEAD, 32'($signed(rand_angle())));
      reg_write(REG_POS_TOL, $urandom_range(65535));
      reg_write(REG_HEAD_TOL, $urandom_range(4096));
      src_idle_pct = (ph % 3 == 0) ? 30 : ((ph % 3 == 1) ? 64 : 0);
      snk_idle_pct = (ph % 3 == 0) ? 64 : ((ph % 3 == 1) ? 30 : 0);
      for (int n = 0; n < 300; n++) random_pose(gx, gy);
      drain();
    end

    if (fail_count == 0) begin
      $display("** go_to_pose_controller_top: PASSED **");
    end else begin
      $display("** go_to_pose_controller_top: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/gtp_pkg.sv
src/gtp_if.sv
src/gtp_regs.sv
src/gtp_dist.sv
src/gtp_cordic.sv
src/go_to_pose_controller_top.sv
verif/go_to_pose_controller_checker.sv
verif/go_to_pose_controller_top_tb.sv
